// ----- src/scs_pkg.sv -----
// Shared types and constants for the 3x3 cross sharpening stream.
package scs_pkg;

    localparam int LINE_DEPTH = 8192;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int MAX_ROWS   = 4096;
    localparam int COL_W      = ADDR_W;
    localparam int ROW_W      = $clog2(MAX_ROWS);

    localparam int CH_W       = 3;
    localparam int RB_W       = 14;
    localparam int RC_W       = 13;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CH_W-1:0] CH_MIN   = 3'd1;
    localparam logic [CH_W-1:0] CH_MAX   = 3'd4;
    localparam logic [CH_W-1:0] CH_RESET = 3'd3;
    localparam logic [RB_W-1:0] RB_MIN   = 14'd3;
    localparam logic [RB_W-1:0] RB_MAX   = RB_W'(LINE_DEPTH);
    localparam logic [RB_W-1:0] RB_RESET = 14'd5760;
    localparam logic [RC_W-1:0] RC_MIN   = 13'd3;
    localparam logic [RC_W-1:0] RC_MAX   = RC_W'(MAX_ROWS);
    localparam logic [RC_W-1:0] RC_RESET = 13'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_ROW_BYTES     = 2'd1,
        CFG_ROW_COUNT     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] sample;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } t_out_item;

    // Position of the item being accepted and what it produces.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr_right;
        logic [ADDR_W-1:0] addr_left;
        logic              emit;
        logic              inner;
        logic              fend;
    } t_pos_info;

endpackage

// ----- src/scs_line_ram.sv -----
// Line store: one write port, two registered read ports.
module scs_line_ram
    import scs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [7:0]        o_rdata_a,
    output logic [7:0]        o_rdata_b
);

    logic [7:0] r_mem [LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ----- src/scs_pos_ctrl.sv -----
// Configuration registers, raster position counters and neighbor addresses.
module scs_pos_ctrl
    import scs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_frame_start,
    output t_pos_info             o_pos
);

    logic [CH_W-1:0]  r_ch, n_ch;
    logic [RB_W-1:0]  r_rb, n_rb;
    logic [RC_W-1:0]  r_rc, n_rc;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [RB_W-1:0]  col_ext, col_inc, col_plus_ch;
    logic [RC_W-1:0]  row_inc;
    logic [CH_W-1:0]  wr_ch;
    logic [RB_W-1:0]  wr_rb;
    logic [RC_W-1:0]  wr_rc;

    // Saturate written values into the supported ranges.
    always_comb begin
        wr_ch = i_cfg_data[CH_W-1:0];
        if (wr_ch < CH_MIN) begin
            wr_ch = CH_MIN;
        end else if (wr_ch > CH_MAX) begin
            wr_ch = CH_MAX;
        end
        wr_rb = i_cfg_data[RB_W-1:0];
        if (wr_rb < RB_MIN) begin
            wr_rb = RB_MIN;
        end else if (wr_rb > RB_MAX) begin
            wr_rb = RB_MAX;
        end
        wr_rc = i_cfg_data[RC_W-1:0];
        if (wr_rc < RC_MIN) begin
            wr_rc = RC_MIN;
        end else if (wr_rc > RC_MAX) begin
            wr_rc = RC_MAX;
        end
    end

    always_comb begin
        n_ch = r_ch;
        n_rb = r_rb;
        n_rc = r_rc;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: n_ch = wr_ch;
                CFG_ROW_BYTES:     n_rb = wr_rb;
                CFG_ROW_COUNT:     n_rc = wr_rc;
                default:           ;
            endcase
        end
    end

    always_comb begin
        cur_col     = i_frame_start ? '0 : r_col;
        cur_row     = i_frame_start ? '0 : r_row;
        col_ext     = {1'b0, cur_col};
        col_inc     = col_ext + 1'b1;
        col_plus_ch = col_ext + {{(RB_W-CH_W){1'b0}}, r_ch};
        row_inc     = {1'b0, cur_row} + 1'b1;

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (col_inc >= r_rb) begin
                n_col = '0;
                n_row = (row_inc >= r_rc) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = cur_row;
            end
        end

        o_pos.col        = cur_col;
        o_pos.addr_right = col_plus_ch[ADDR_W-1:0];
        o_pos.addr_left  = cur_col - {{(ADDR_W-CH_W){1'b0}}, r_ch};
        o_pos.emit       = (cur_row != '0);
        o_pos.inner      = (cur_row >= ROW_W'(2)) && (row_inc <= r_rc)
                         && (col_ext >= {{(RB_W-CH_W){1'b0}}, r_ch})
                         && (col_plus_ch < r_rb);
        o_pos.fend       = (row_inc == r_rc) && (col_inc == r_rb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= CH_RESET;
            r_rb  <= RB_RESET;
            r_rc  <= RC_RESET;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_ch  <= n_ch;
            r_rb  <= n_rb;
            r_rc  <= n_rc;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- src/scs_kernel.sv -----
// Cross kernel: 5x center minus four neighbors, saturated to a byte; 0 off inner.
module scs_kernel
    import scs_pkg::*;
(
    input  logic       i_inner,
    input  logic [7:0] i_centre,
    input  logic [7:0] i_left,
    input  logic [7:0] i_right,
    input  logic [7:0] i_up,
    input  logic [7:0] i_down,
    output logic [7:0] o_pixel
);

    logic [10:0]       five_c;
    logic [9:0]        neigh;
    logic signed [11:0] diff;

    always_comb begin
        five_c = {1'b0, i_centre, 2'b00} + {3'b000, i_centre};
        neigh  = {2'b00, i_left} + {2'b00, i_right} + {2'b00, i_up} + {2'b00, i_down};
        diff   = $signed({1'b0, five_c}) - $signed({2'b00, neigh});
        if (!i_inner || diff < 0) begin
            o_pixel = '0;
        end else if (diff > 12'sd255) begin
            o_pixel = 8'hFF;
        end else begin
            o_pixel = diff[7:0];
        end
    end

endmodule

// ----- src/sharpen_3x3_cross_stream.sv -----
// Top level of the streaming 3x3 cross sharpening filter.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_data  (t_in_item)
//  result    out        o_valid / i_stall         o_data  (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per clock sustained while the result side does not stall.
// An accepted item passes the line store read registers, then the result register.
// Rate is set by the line stores: each has one write and two reads per cycle.
// Reset (synchronous, active low) clears counters and valid flags and loads the
// register defaults; the line stores are not cleared.
// o_stall rises only when both the read stage and the result register are full
// and the result side stalls; a held result never blocks a new item otherwise.
module sharpen_3x3_cross_stream
    import scs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_pos_info pos;

    logic accept;
    logic can_load2;
    logic s1_leave;

    // Read stage: memory read data lives inside the line stores.
    logic              r_v1;
    logic [COL_W-1:0]  r_col1;
    logic [7:0]        r_down1;
    logic              r_inner1;
    logic              r_fend1;
    logic              r_emit1;
    logic              r_fwd_left1;
    logic              r_fwd_up1;
    logic [7:0]        r_fwd_data1;

    // Result register.
    logic              r_v2;
    t_out_item         r_out2;

    logic [7:0] mid_centre, mid_right;
    logic [7:0] abv_left, abv_up;
    logic [7:0] left_sel, up_sel;
    logic [7:0] pixel;

    assign o_cfg_ready = 1'b1;

    // Result register may load when empty or being drained this cycle.
    assign can_load2 = !r_v2 || !i_stall;
    assign s1_leave  = r_v1 && can_load2;
    assign o_stall   = r_v1 && !can_load2;
    assign accept    = i_valid && !o_stall;

    scs_pos_ctrl u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_frame_start (i_data.frame_start),
        .o_pos         (pos)
    );

    // Row one above the input: write the new sample, read center and right.
    scs_line_ram u_line_middle (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (pos.col),
        .i_wdata   (i_data.sample),
        .i_re      (accept),
        .i_raddr_a (pos.col),
        .i_raddr_b (pos.addr_right),
        .o_rdata_a (mid_centre),
        .o_rdata_b (mid_right)
    );

    // Row two above: takes the old middle byte when the item leaves the read
    // stage, so the write lags that item's reads.
    scs_line_ram u_line_above (
        .i_clk     (i_clk),
        .i_we      (s1_leave),
        .i_waddr   (r_col1),
        .i_wdata   (mid_centre),
        .i_re      (accept),
        .i_raddr_a (pos.addr_left),
        .i_raddr_b (pos.col),
        .o_rdata_a (abv_left),
        .o_rdata_b (abv_up)
    );

    // Read stage: the item in it always leaves on a cycle that accepts a new
    // one, so its pending above-row write must bypass the new item's reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (s1_leave) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col1      <= pos.col;
            r_down1     <= i_data.sample;
            r_inner1    <= pos.inner;
            r_fend1     <= pos.fend;
            r_emit1     <= pos.emit;
            r_fwd_left1 <= r_v1 && (pos.addr_left == r_col1);
            r_fwd_up1   <= r_v1 && (pos.col == r_col1);
            r_fwd_data1 <= mid_centre;
        end
    end

    // Take the bypassed byte where the above-row write was still pending.
    assign left_sel = r_fwd_left1 ? r_fwd_data1 : abv_left;
    assign up_sel   = r_fwd_up1   ? r_fwd_data1 : abv_up;

    scs_kernel u_kernel (
        .i_inner  (r_inner1),
        .i_centre (mid_centre),
        .i_left   (left_sel),
        .i_right  (mid_right),
        .i_up     (up_sel),
        .i_down   (r_down1),
        .o_pixel  (pixel)
    );

    // Result register: drop items of the first row, which emit nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (can_load2) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load2) begin
            r_out2.pixel_out <= pixel;
            r_out2.frame_end <= r_fend1;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out2;

endmodule
